// ===== hdl/tcms_pkg.sv =====
// Shared types, widths, reset values and helper functions for the two-cable
// move segmenter. No dependencies; every other file imports this package.
`default_nettype none

package tcms_pkg;

    localparam int C_COORD_W    = 24;
    localparam int C_DELTA_W    = 25;
    localparam int C_MAG_W      = 25;
    localparam int C_MOTOR_W    = 25;
    localparam int C_CABLE_W    = 25;
    localparam int C_SEGLEN_W   = 20;
    localparam int C_RAD_W      = 50;
    localparam int C_ROOT_W     = C_RAD_W / 2;
    localparam int C_DIST_W     = C_ROOT_W + 1;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 24;
    localparam int C_MAX_SEGMENTS = 64;

    localparam logic [C_SEGLEN_W-1:0]       C_RST_SEG_LEN  = 20'd10240;
    localparam logic signed [C_COORD_W-1:0] C_RST_LEFT_AX  = -24'sd273408;
    localparam logic signed [C_COORD_W-1:0] C_RST_RIGHT_AX = 24'sd273408;
    localparam logic signed [C_COORD_W-1:0] C_RST_ANCHOR_Y = 24'sd256000;
    localparam logic [C_COORD_W-1:0]        C_RST_ZERO_LEN = 24'd374550;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] CFG_SEG_SPAN          = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_LEFT_ANCHOR_X     = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RIGHT_ANCHOR_X    = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_LEFT_ANCHOR_Y     = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RIGHT_ANCHOR_Y    = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ZERO_LEFT_LENGTH  = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ZERO_RIGHT_LENGTH = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_SUM,
        ST_SQRT,
        ST_COUNT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STEP,
        ST_POS,
        ST_CAB_L,
        ST_CAB_R,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_DIST,
        PH_LEFT,
        PH_RIGHT
    } t_phase;

    function automatic logic [C_MAG_W-1:0] f_mag(input logic signed [C_DELTA_W-1:0] v);
        return v[C_DELTA_W-1] ? C_MAG_W'(-v) : C_MAG_W'(v);
    endfunction

    // clamp a 27-bit difference into the signed motor range
    function automatic logic signed [C_MOTOR_W-1:0] f_sat(input logic signed [26:0] v);
        logic signed [26:0] hi;
        logic signed [26:0] lo;
        hi = 27'sd16777215;
        lo = -27'sd16777216;
        if (v > hi) begin
            return C_MOTOR_W'(hi);
        end else if (v < lo) begin
            return C_MOTOR_W'(lo);
        end
        return C_MOTOR_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tcms_if.sv =====
// Handshake channels of the move segmenter: move input, segment output and
// configuration write. Depends on tcms_pkg for field widths.
`default_nettype none

interface tcms_move_if import tcms_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [C_COORD_W-1:0] start_x;
    logic signed [C_COORD_W-1:0] start_y;
    logic signed [C_COORD_W-1:0] start_z;
    logic signed [C_COORD_W-1:0] target_x;
    logic signed [C_COORD_W-1:0] target_y;
    logic signed [C_COORD_W-1:0] target_z;
    logic                        rapid;
    modport source(output valid, start_x, start_y, start_z, target_x, target_y,
                   target_z, rapid, input ready);
    modport sink(input valid, start_x, start_y, start_z, target_x, target_y,
                 target_z, rapid, output ready);
endinterface

interface tcms_seg_if import tcms_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [C_MOTOR_W-1:0] left_motor;
    logic signed [C_MOTOR_W-1:0] right_motor;
    logic signed [C_COORD_W-1:0] z_position;
    logic                        last_segment;
    modport source(output valid, left_motor, right_motor, z_position, last_segment,
                   input ready);
    modport sink(input valid, left_motor, right_motor, z_position, last_segment,
                 output ready);
endinterface

interface tcms_cfg_if import tcms_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [C_CFG_IDX_W-1:0]  index;
    logic [C_CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/two_cable_move_segmenter.sv =====
// Two-cable move segmenter, top level: sequencer, interpolation lanes and
// output register. Uses tcms_pkg, tcms_if, tcms_sqrt and tcms_div.
//
// One move transaction in, one segment transaction out per segment. The XY
// length of the move is found with a square root rounded up, the segment
// count is found by stepping a running multiple of the segment span (capped
// at MAX_SEGMENTS; a rapid move is one segment), and each axis delta is
// divided once by the count in a bit-serial divider. Points along the move
// then come from a quotient/remainder accumulator per axis, which gives
// start + round(delta*k/n) with ties away from zero. Both cable lengths of
// a point come from a shared squarer and the bit-serial square root,
// rounded to nearest. A rapid move skips the length and the count; each
// segment then takes two square roots, one per cable. The move port is
// ready only while no move is in progress. A finished segment waits in the
// output register while the next one is being computed. A non-rapid move
// with no XY travel gives one segment at the last cable lengths if Z
// changes, and nothing otherwise. Motor outputs saturate to 25 bits signed.
// Configuration writes are taken at any time but belong in idle periods.
`default_nettype none

module two_cable_move_segmenter import tcms_pkg::*; #(
    parameter int MAX_SEGMENTS = C_MAX_SEGMENTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcms_move_if.sink    i_move,
    tcms_seg_if.source   o_seg,
    tcms_cfg_if.sink     i_cfg
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int LACC_W = C_SEGLEN_W + CNT_W;
    localparam int CMP_W  = LACC_W + C_DIST_W;
    localparam int REM_W  = C_ROOT_W + 2;

    // configuration registers
    logic [C_SEGLEN_W-1:0]       r_seg_len;
    logic signed [C_COORD_W-1:0] r_lax;
    logic signed [C_COORD_W-1:0] r_rax;
    logic signed [C_COORD_W-1:0] r_lay;
    logic signed [C_COORD_W-1:0] r_ray;
    logic [C_COORD_W-1:0]        r_zl;
    logic [C_COORD_W-1:0]        r_zr;

    // sequencer
    t_state r_state;
    t_state n_state;
    t_phase r_phase;

    // per-axis lanes: 0 = X, 1 = Y, 2 = Z
    logic signed [C_COORD_W-1:0] r_start [3];
    logic                        r_neg   [3];
    logic [C_MAG_W-1:0]          r_mag   [3];
    logic [C_MAG_W-1:0]          r_quo   [3];
    logic [CNT_W-1:0]            r_rmd   [3];
    logic [C_MAG_W-1:0]          r_qacc  [3];
    logic [CNT_W-1:0]            r_racc  [3];
    logic signed [C_COORD_W-1:0] r_pos   [3];
    logic [1:0]                  r_ci;
    logic                        r_dz_nz;

    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_k;
    logic [LACC_W-1:0]  r_lenacc;
    logic [C_DIST_W-1:0] r_dist;

    logic [C_MAG_W-1:0] r_ea;
    logic [C_MAG_W-1:0] r_eb;
    logic [C_RAD_W-1:0] r_prod;
    logic [C_RAD_W-1:0] r_acc;

    logic [C_CABLE_W-1:0] r_cab_l;
    logic [C_CABLE_W-1:0] r_cab_r;

    // output register
    logic                        r_ovalid;
    logic signed [C_MOTOR_W-1:0] r_olm;
    logic signed [C_MOTOR_W-1:0] r_orm;
    logic signed [C_COORD_W-1:0] r_oz;
    logic                        r_olast;

    // datapath nets
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_sqrt_start;
    logic                        w_sqrt_done;
    logic [C_ROOT_W-1:0]         w_root;
    logic [REM_W-1:0]            w_rem;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [C_MAG_W-1:0]          w_div_quo;
    logic [CNT_W-1:0]            w_div_rmd;
    logic [C_MAG_W-1:0]          w_mop;
    logic [C_RAD_W-1:0]          w_sq;
    logic [C_RAD_W-1:0]          w_rad;
    logic [C_SEGLEN_W-1:0]       w_len;
    logic                        w_count_done;
    logic                        w_dist_zero;
    logic [C_CABLE_W-1:0]        w_round;
    logic                        w_last;
    logic signed [C_DELTA_W-1:0] w_dx;
    logic signed [C_DELTA_W-1:0] w_dy;
    logic signed [C_DELTA_W-1:0] w_dz;

    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_move.valid && i_move.ready;
    assign w_out_free  = !r_ovalid || o_seg.ready;

    assign w_dx = C_DELTA_W'(i_move.target_x) - C_DELTA_W'(i_move.start_x);
    assign w_dy = C_DELTA_W'(i_move.target_y) - C_DELTA_W'(i_move.start_y);
    assign w_dz = C_DELTA_W'(i_move.target_z) - C_DELTA_W'(i_move.start_z);

    // zero segment length acts as one
    assign w_len = (r_seg_len == '0) ? C_SEGLEN_W'(1) : r_seg_len;

    // one shared squarer, registered before the add
    assign w_mop = (r_state == ST_SQ_A) ? r_ea : r_eb;
    assign w_sq  = C_RAD_W'(w_mop) * C_RAD_W'(w_mop);
    assign w_rad = r_acc + r_prod;

    assign w_dist_zero  = (w_root == '0) && (w_rem == '0);
    assign w_round      = w_root + C_CABLE_W'(REM_W'(w_root) < w_rem);
    assign w_count_done = (CMP_W'(r_lenacc) >= CMP_W'(r_dist)) ||
                          (r_n == CNT_W'(MAX_SEGMENTS));
    assign w_last       = (r_k == r_n);

    tcms_sqrt #(
        .RAD_W (C_RAD_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_rad),
        .o_done     (w_sqrt_done),
        .o_root     (w_root),
        .o_rem      (w_rem)
    );

    tcms_div #(
        .DVD_W (C_MAG_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag[r_ci]),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rmd      (w_div_rmd)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= C_RST_SEG_LEN;
            r_lax     <= C_RST_LEFT_AX;
            r_rax     <= C_RST_RIGHT_AX;
            r_lay     <= C_RST_ANCHOR_Y;
            r_ray     <= C_RST_ANCHOR_Y;
            r_zl      <= C_RST_ZERO_LEN;
            r_zr      <= C_RST_ZERO_LEN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SEG_SPAN:          r_seg_len <= i_cfg.data[C_SEGLEN_W-1:0];
                CFG_LEFT_ANCHOR_X:     r_lax     <= $signed(i_cfg.data);
                CFG_RIGHT_ANCHOR_X:    r_rax     <= $signed(i_cfg.data);
                CFG_LEFT_ANCHOR_Y:     r_lay     <= $signed(i_cfg.data);
                CFG_RIGHT_ANCHOR_Y:    r_ray     <= $signed(i_cfg.data);
                CFG_ZERO_LEFT_LENGTH:  r_zl      <= i_cfg.data;
                CFG_ZERO_RIGHT_LENGTH: r_zr      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        n_state      = r_state;
        i_move.ready = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_move.ready = 1'b1;
                if (i_move.valid) begin
                    n_state = i_move.rapid ? ST_DIV_GO : ST_SQ_A;
                end
            end
            ST_SQ_A:   n_state = ST_SQ_B;
            ST_SQ_B:   n_state = ST_SQ_SUM;
            ST_SQ_SUM: begin
                w_sqrt_start = 1'b1;
                n_state      = ST_SQRT;
            end
            ST_SQRT: begin
                if (w_sqrt_done) begin
                    unique case (r_phase)
                        PH_DIST: begin
                            if (!w_dist_zero) begin
                                n_state = ST_COUNT;
                            end else if (r_dz_nz) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        PH_LEFT:  n_state = ST_CAB_R;
                        PH_RIGHT: n_state = ST_EMIT;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_COUNT: begin
                if (w_count_done) begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_ci == 2'd2) ? ST_STEP : ST_DIV_GO;
                end
            end
            ST_STEP:  n_state = ST_POS;
            ST_POS:   n_state = ST_CAB_L;
            ST_CAB_L: n_state = ST_SQ_A;
            ST_CAB_R: n_state = ST_SQ_A;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last ? ST_IDLE : ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // move datapath
    always_ff @(posedge i_clk) begin
        logic [CNT_W:0]              sum;
        logic signed [C_COORD_W+1:0] pos;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // latch the move; Z target doubles as the no-travel result
                    r_start[0] <= i_move.start_x;
                    r_start[1] <= i_move.start_y;
                    r_start[2] <= i_move.start_z;
                    r_neg[0]   <= w_dx[C_DELTA_W-1];
                    r_neg[1]   <= w_dy[C_DELTA_W-1];
                    r_neg[2]   <= w_dz[C_DELTA_W-1];
                    r_mag[0]   <= f_mag(w_dx);
                    r_mag[1]   <= f_mag(w_dy);
                    r_mag[2]   <= f_mag(w_dz);
                    r_ea       <= f_mag(w_dx);
                    r_eb       <= f_mag(w_dy);
                    r_dz_nz    <= (w_dz != '0);
                    r_pos[2]   <= i_move.target_z;
                    r_phase    <= PH_DIST;
                    r_k        <= '0;
                    r_n        <= i_move.rapid ? CNT_W'(1) : '0;
                    r_ci       <= '0;
                end
            end
            ST_SQ_A: r_prod <= w_sq;
            ST_SQ_B: begin
                r_acc  <= r_prod;
                r_prod <= w_sq;
            end
            ST_SQRT: begin
                if (w_sqrt_done) begin
                    unique case (r_phase)
                        PH_DIST: begin
                            // round the travel up, start counting at one segment
                            r_dist   <= C_DIST_W'(w_root) + C_DIST_W'(w_rem != '0);
                            r_n      <= w_dist_zero ? '0 : CNT_W'(1);
                            r_lenacc <= LACC_W'(w_len);
                        end
                        PH_LEFT:  r_cab_l <= w_round;
                        PH_RIGHT: r_cab_r <= w_round;
                        default: ;
                    endcase
                end
            end
            ST_COUNT: begin
                if (!w_count_done) begin
                    r_lenacc <= r_lenacc + LACC_W'(w_len);
                    r_n      <= r_n + 1'b1;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_quo[r_ci]  <= w_div_quo;
                    r_rmd[r_ci]  <= w_div_rmd;
                    r_qacc[r_ci] <= '0;
                    r_racc[r_ci] <= r_n >> 1;
                    r_ci         <= r_ci + 1'b1;
                end
            end
            ST_STEP: begin
                // advance each axis by delta/n, carry the remainder
                for (int i = 0; i < 3; i++) begin
                    sum = {1'b0, r_racc[i]} + {1'b0, r_rmd[i]};
                    if (sum >= {1'b0, r_n}) begin
                        r_racc[i] <= CNT_W'(sum - {1'b0, r_n});
                        r_qacc[i] <= r_qacc[i] + r_quo[i] + 1'b1;
                    end else begin
                        r_racc[i] <= sum[CNT_W-1:0];
                        r_qacc[i] <= r_qacc[i] + r_quo[i];
                    end
                end
                r_k <= r_k + 1'b1;
            end
            ST_POS: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_neg[i]) begin
                        pos = (C_COORD_W + 2)'(r_start[i]) - $signed({1'b0, r_qacc[i]});
                    end else begin
                        pos = (C_COORD_W + 2)'(r_start[i]) + $signed({1'b0, r_qacc[i]});
                    end
                    r_pos[i] <= pos[C_COORD_W-1:0];
                end
            end
            ST_CAB_L: begin
                r_ea    <= f_mag(C_DELTA_W'(r_lax) - C_DELTA_W'(r_pos[0]));
                r_eb    <= f_mag(C_DELTA_W'(r_lay) - C_DELTA_W'(r_pos[1]));
                r_phase <= PH_LEFT;
            end
            ST_CAB_R: begin
                r_ea    <= f_mag(C_DELTA_W'(r_rax) - C_DELTA_W'(r_pos[0]));
                r_eb    <= f_mag(C_DELTA_W'(r_ray) - C_DELTA_W'(r_pos[1]));
                r_phase <= PH_RIGHT;
            end
            default: ;
        endcase
        // cable lengths are kept across moves; reset loads the zero length into them
        if (!i_rst_n) begin
            r_cab_l <= C_CABLE_W'(C_RST_ZERO_LEN);
            r_cab_r <= C_CABLE_W'(C_RST_ZERO_LEN);
        end
    end

    // output register: hold a finished segment until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_seg.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_olm   <= f_sat($signed({3'b000, r_zl}) - $signed({2'b00, r_cab_l}));
            r_orm   <= f_sat($signed({2'b00, r_cab_r}) - $signed({3'b000, r_zr}));
            r_oz    <= r_pos[2];
            r_olast <= w_last;
        end
    end

    assign o_seg.valid        = r_ovalid;
    assign o_seg.left_motor   = r_olm;
    assign o_seg.right_motor  = r_orm;
    assign o_seg.z_position   = r_oz;
    assign o_seg.last_segment = r_olast;

endmodule

`default_nettype wire

// ===== hdl/tcms_sqrt.sv =====
// Digit-serial integer square root: one root bit per cycle, two radicand
// bits shifted in per cycle. Uses tcms_pkg.
`default_nettype none

module tcms_sqrt import tcms_pkg::*; #(
    parameter int RAD_W = C_RAD_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [RAD_W-1:0]         i_radicand,
    output logic                     o_done,
    output logic [RAD_W/2-1:0]       o_root,
    output logic [RAD_W/2+1:0]       o_rem
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  w_t;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    assign w_t     = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = (REM_W + 2)'({r_root, 2'b01});
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_t[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/tcms_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses tcms_pkg for the default dividend width.
`default_nettype none

module tcms_div import tcms_pkg::*; #(
    parameter int DVD_W = C_MAG_W,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rmd
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_t;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_t    = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_dvs});
    assign w_diff = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_t[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;
    assign o_rmd  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/tcms_checker.sv =====
// Port-level checks for the two-cable move segmenter, attached by bind.
// Depends on tcms_pkg and the top level two_cable_move_segmenter.
`default_nettype none

module tcms_checker import tcms_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_move_valid,
    input logic                        i_move_ready,
    input logic                        i_seg_valid,
    input logic                        i_seg_ready,
    input logic signed [C_MOTOR_W-1:0] i_seg_left,
    input logic signed [C_MOTOR_W-1:0] i_seg_right,
    input logic signed [C_COORD_W-1:0] i_seg_z,
    input logic                        i_seg_last
);

    // a move in progress blocks the next one
    a_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_move_valid && i_move_ready |=> !i_move_ready)
        else $error("move port ready right after a move transaction");

    // while a non-final segment is out, the move is still running
    a_mid_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && !i_seg_last |-> !i_move_ready)
        else $error("move port ready before the last segment");

    // stalled segment holds
    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && !i_seg_ready |=> i_seg_valid &&
            $stable(i_seg_left) && $stable(i_seg_right) &&
            $stable(i_seg_z) && $stable(i_seg_last))
        else $error("stalled segment changed");

endmodule

bind two_cable_move_segmenter tcms_checker u_tcms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_move_valid (i_move.valid),
    .i_move_ready (i_move.ready),
    .i_seg_valid  (o_seg.valid),
    .i_seg_ready  (o_seg.ready),
    .i_seg_left   (o_seg.left_motor),
    .i_seg_right  (o_seg.right_motor),
    .i_seg_z      (o_seg.z_position),
    .i_seg_last   (o_seg.last_segment)
);

`default_nettype wire

// ===== tb/sv/tcms_tb_if.sv =====
// Testbench copies of the segmenter's handshake channels are not needed: the
// RTL interfaces from tcms_if are used directly. This file holds small move
// and segment record types for the checker and stimulus top. Uses tcms_pkg.
package tcms_tb_pkg;
    import tcms_pkg::*;

    typedef struct packed {
        logic signed [C_COORD_W-1:0] sx;
        logic signed [C_COORD_W-1:0] sy;
        logic signed [C_COORD_W-1:0] sz;
        logic signed [C_COORD_W-1:0] tx;
        logic signed [C_COORD_W-1:0] ty;
        logic signed [C_COORD_W-1:0] tz;
        logic                        rapid;
    } t_move;

    typedef struct packed {
        logic signed [C_MOTOR_W-1:0] left_motor;
        logic signed [C_MOTOR_W-1:0] right_motor;
        logic signed [C_COORD_W-1:0] z_position;
        logic                        last_segment;
    } t_segment;
endpackage

// ===== tb/sv/tcms_checker.sv =====
// Checker for the two-cable move segmenter: watches move, segment and config
// transactions, predicts segments and compares. Uses tcms_pkg, tcms_tb_pkg.
module tcms_scoreboard import tcms_pkg::*; import tcms_tb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcms_move_if             mv,
    tcms_seg_if              sg,
    tcms_cfg_if              cf,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [19:0]        seg_len;
    longint             lax, rax, lay, ray;
    longint unsigned    zl, zr;
    longint unsigned    cab_l, cab_r;
    longint             z_last;
    t_segment           seg_queue[$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned amag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint interp(longint s, longint d, int k, int n);
        longint p;
        longint unsigned q;
        p = d * k;
        q = (amag(p) + n / 2) / n;
        return p < 0 ? s - longint'(q) : s + longint'(q);
    endfunction

    function automatic longint unsigned cable_len(longint ax, longint ay, longint x, longint y);
        longint unsigned ex, ey, s, r;
        ex = amag(ax - x);
        ey = amag(ay - y);
        s = ex * ex + ey * ey;
        r = isqrt(s);
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic logic signed [C_MOTOR_W-1:0] clamp_motor(longint v);
        if (v > 16777215) return 25'sd16777215;
        if (v < -16777216) return -25'sd16777216;
        return C_MOTOR_W'(v);
    endfunction

    function automatic t_segment segment_now(logic last);
        t_segment e;
        e.left_motor = clamp_motor(longint'(zl) - longint'(cab_l));
        e.right_motor = clamp_motor(longint'(cab_r) - longint'(zr));
        e.z_position = C_COORD_W'(z_last);
        e.last_segment = last;
        return e;
    endfunction

    task automatic predict_move(t_move m);
        longint dx, dy, dz, x, y;
        longint unsigned s, d, len, n;
        dx = longint'(m.tx) - m.sx;
        dy = longint'(m.ty) - m.sy;
        dz = longint'(m.tz) - m.sz;
        if (m.rapid) begin
            n = 1;
        end else begin
            s = amag(dx) * amag(dx) + amag(dy) * amag(dy);
            d = isqrt(s);
            if (d * d < s) d++;
            len = seg_len == 0 ? 1 : seg_len;
            n = (d + len - 1) / len;
        end
        if (n > C_MAX_SEGMENTS) n = C_MAX_SEGMENTS;
        if (n == 0) begin
            if (dz != 0) begin
                z_last = m.tz;
                seg_queue.push_back(segment_now(1'b1));
            end
        end else begin
            for (int k = 1; k <= int'(n); k++) begin
                x = interp(m.sx, dx, k, n);
                y = interp(m.sy, dy, k, n);
                z_last = interp(m.sz, dz, k, n);
                cab_l = cable_len(lax, lay, x, y);
                cab_r = cable_len(rax, ray, x, y);
                seg_queue.push_back(segment_now(k == int'(n)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_segment got, want;
        if (!i_rst_n) begin
            seg_len <= 20'd10240;
            lax = -273408; rax = 273408; lay = 256000; ray = 256000;
            zl = 374550; zr = 374550; cab_l = 374550; cab_r = 374550; z_last = 0;
            seg_queue.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            // Check outputs before this edge's move so ordering is by queue only.
            if (sg.valid && sg.ready) begin
                got = {sg.left_motor, sg.right_motor, sg.z_position, sg.last_segment};
                if (seg_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected segment %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = seg_queue.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("segment mismatch: expected %p actual %p", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (mv.valid && mv.ready)
                predict_move({mv.start_x, mv.start_y, mv.start_z, mv.target_x,
                              mv.target_y, mv.target_z, mv.rapid});
            if (cf.valid && cf.ready) begin
                case (cf.index)
                    CFG_SEG_SPAN:          seg_len <= cf.data[19:0];
                    CFG_LEFT_ANCHOR_X:     lax = longint'(signed'(cf.data));
                    CFG_RIGHT_ANCHOR_X:    rax = longint'(signed'(cf.data));
                    CFG_LEFT_ANCHOR_Y:     lay = longint'(signed'(cf.data));
                    CFG_RIGHT_ANCHOR_Y:    ray = longint'(signed'(cf.data));
                    CFG_ZERO_LEFT_LENGTH:  zl = cf.data;
                    CFG_ZERO_RIGHT_LENGTH: zr = cf.data;
                    default: ;
                endcase
            end
            o_pending <= seg_queue.size();
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Stimulus and verdict for the two-cable move segmenter: drives moves and
// config writes, stalls the segment sink. Uses tcms_pkg, tcms_tb_pkg, checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcms_pkg::*;
    import tcms_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, cycles;
    int   send_idle_pct, recv_idle_pct;

    tcms_move_if mv();
    tcms_seg_if  sg();
    tcms_cfg_if  cf();

    two_cable_move_segmenter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_move(mv), .o_seg(sg), .i_cfg(cf)
    );

    tcms_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .mv(mv), .sg(sg), .cf(cf),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: worst case is ~64 segments per move with a 2/3 stalled sink.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 4000000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Segment sink: stall at the configured rate, drive at the falling edge.
    always @(negedge i_clk) begin
        sg.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic cfg_write(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cf.valid <= 1'b1;
        cf.index <= idx;
        cf.data  <= val;
        @(posedge i_clk);
        while (!cf.ready) @(posedge i_clk);
        @(negedge i_clk);
        cf.valid <= 1'b0;
    endtask

    // Hold a move until accepted; idle random cycles beforehand.
    task automatic send_move(t_move m);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        {mv.start_x, mv.start_y, mv.start_z, mv.target_x, mv.target_y,
         mv.target_z, mv.rapid} <= m;
        mv.valid <= 1'b1;
        @(posedge i_clk);
        while (!mv.ready) @(posedge i_clk);
        @(negedge i_clk);
        mv.valid <= 1'b0;
    endtask

    // Drain: wait until nothing is expected, then let the block settle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic t_move short_move(int span);
        t_move m;
        m.sx = 24'($signed(24'($urandom_range(400000))) - 200000);
        m.sy = 24'($signed(24'($urandom_range(400000))) - 200000);
        m.sz = $signed(24'($urandom));
        m.tx = 24'(m.sx + $signed(24'($urandom_range(2 * span))) - span);
        m.ty = 24'(m.sy + $signed(24'($urandom_range(2 * span))) - span);
        m.tz = ($urandom_range(3) == 0) ? m.sz : $signed(24'($urandom));
        m.rapid = ($urandom_range(5) == 0);
        return m;
    endfunction

    function automatic t_move wild_move();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_move)-1:0];
    endfunction

    task automatic random_phase(int count);
        t_move m;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       m = wild_move();
                1:       begin m = short_move(0); end
                default: m = short_move(60000);
            endcase
            send_move(m);
        end
    endtask

    initial begin
        send_idle_pct = 25;
        recv_idle_pct = 66;
        i_rst_n  = 1'b0;
        mv.valid = 1'b0;
        {mv.start_x, mv.start_y, mv.start_z, mv.target_x, mv.target_y,
         mv.target_z, mv.rapid} = '0;
        cf.valid = 1'b0;
        cf.index = CFG_SEG_SPAN;
        cf.data  = '0;
        sg.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: defaults first, then special cases.
        send_move('{0, 0, 0, 20000, 15000, 100, 0});
        send_move('{20000, 15000, 100, 20000, 15000, 500, 0});  // Z only
        send_move('{20000, 15000, 500, 20000, 15000, 500, 0});  // no motion
        send_move('{5, 5, 5, 5, 5, 5, 1});                       // rapid, no travel
        send_move('{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0});
        send_move('{8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1});
        send_move('{0, 0, 0, 3, -3, -1, 0});
        send_move('{-7, 9, 1, 10240, 0, -1, 0});                 // just over one span
        drain();  // sender holds until all segments are in

        // Extreme configuration: smallest segment, saturating anchors/zeros.
        cfg_write(CFG_SEG_SPAN, 24'd0);
        cfg_write(CFG_LEFT_ANCHOR_X, 24'h800000);
        cfg_write(CFG_RIGHT_ANCHOR_X, 24'h7FFFFF);
        cfg_write(CFG_LEFT_ANCHOR_Y, 24'h7FFFFF);
        cfg_write(CFG_RIGHT_ANCHOR_Y, 24'h800000);
        cfg_write(CFG_ZERO_LEFT_LENGTH, 24'hFFFFFF);
        cfg_write(CFG_ZERO_RIGHT_LENGTH, 24'h000000);
        send_move('{0, 0, 0, 5, 2, 9, 0});
        send_move('{-8388608, 8388607, 0, 8388607, -8388608, 0, 0});
        send_move('{1, 1, 1, 1, 1, 7, 0});
        send_move('{100, 100, 0, -100, 20, 3, 1});
        drain();

        cfg_write(CFG_SEG_SPAN, 24'hFFFFF);
        cfg_write(CFG_ZERO_LEFT_LENGTH, 24'd0);
        cfg_write(CFG_ZERO_RIGHT_LENGTH, 24'hFFFFFF);
        send_move('{-8388608, -8388608, 0, 8388607, 8388607, 0, 0});
        send_move('{0, 0, 0, 1, 0, 0, 0});
        random_phase(20);
        drain();

        // Back to typical geometry, swap idling rates.
        cfg_write(CFG_SEG_SPAN, 24'd20000);
        cfg_write(CFG_LEFT_ANCHOR_X, -24'sd273408);
        cfg_write(CFG_RIGHT_ANCHOR_X, 24'sd273408);
        cfg_write(CFG_LEFT_ANCHOR_Y, 24'sd256000);
        cfg_write(CFG_RIGHT_ANCHOR_Y, 24'sd256000);
        cfg_write(CFG_ZERO_LEFT_LENGTH, 24'd374550);
        cfg_write(CFG_ZERO_RIGHT_LENGTH, 24'd374550);
        random_phase(30);
        send_idle_pct = 66;
        recv_idle_pct = 25;
        random_phase(30);
        drain();

        cfg_write(CFG_SEG_SPAN, 24'($urandom_range(1, 40000)));
        cfg_write(CFG_LEFT_ANCHOR_X, 24'($urandom));
        cfg_write(CFG_RIGHT_ANCHOR_X, 24'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/tcms_pkg.sv
hdl/tcms_if.sv
hdl/tcms_sqrt.sv
hdl/tcms_div.sv
hdl/two_cable_move_segmenter.sv
hdl/tcms_checker.sv
tb/sv/tcms_tb_if.sv
tb/sv/tcms_checker.sv
tb/sv/tb_top.sv
